FILE: rtl/qet_pkg.sv
package qet_pkg;

   // Tokens accepted per line never exceed this, whatever the register holds.
   localparam int TOKEN_LIMIT = 64;

   localparam logic [6:0] MAX_TOKENS_RESET = 7'd64;

   // Register index of max_tokens in the register file.
   localparam logic REG_MAX_TOKENS = 1'b0;

   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_END  = 2'd1,
      KIND_DONE = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      QUOTE_NONE   = 2'd0,
      QUOTE_SINGLE = 2'd1,
      QUOTE_DOUBLE = 2'd2
   } quote_mode_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       line_end;
   } req_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] char_out;
      logic [5:0] token_number;
      logic [6:0] token_total;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic           escape_pending;
      quote_mode_type quote_mode;
      logic           token_open;
      logic [6:0]     token_count;
      logic           line_stopped;
   } state_type;

   // Up to three results per transaction, in order from entry 0.
   typedef struct packed {
      rsp_type [2:0] result;
      logic    [1:0] count;
   } step_type;

endpackage

FILE: rtl/quoted_escaped_tokenizer_core.sv
// Command line tokenizer: one character per request transaction, with
// line_end set on the last character of a line. Each transaction yields
// zero to three response transactions: token bytes (kind byte), an end
// mark after each token (kind end) and one line-done response per line
// carrying the token count (kind done). last_of_run flags the final
// response of a request. A NUL, or a character that would start a token
// beyond the limit, ends the line early and later characters are dropped.
// The max_tokens register (byte address 0) sets the per-line token limit,
// saturating at the built-in ceiling; write it only while the core is idle.
// The first response of a request is offered in the cycle after the
// request is accepted. A request that yields at most one response can be
// accepted every cycle while rsp_ready is high; one yielding more holds
// the result stage until its last response is taken, one per ready cycle.
// A request is accepted while the result stage is empty or handing over
// its last response, so a stalled receiver backs up into req_ready.
// Reset clears the parsing state and the result stage and loads
// max_tokens with 64; no clearing pass is needed.
module quoted_escaped_tokenizer_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  qet_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output qet_pkg::rsp_type rsp_payload,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import qet_pkg::*;

   state_type  state_ff;
   state_type  state_in;
   state_type  state_next;
   step_type   step;
   logic [6:0] max_tokens;
   logic       accept;
   logic       free;

   // Register file: holds the token limit.
   qet_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .max_tokens (max_tokens)
   );

   // Per-character decode: next parse state and the responses of this
   // transaction, all in one pass of shallow logic.
   qet_step u_step (
      .cur        (state_ff),
      .req        (req_payload),
      .max_tokens (max_tokens),
      .nxt        (state_next),
      .step       (step)
   );

   assign req_ready = free;
   assign accept    = req_valid && req_ready;

   // The parse state advances only on an accepted transaction.
   always_comb begin
      state_in = state_ff;
      if (accept) begin
         state_in = state_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   // Result stage: holds up to three responses and presents them in order.
   qet_out u_out (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .step        (step),
      .free        (free),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   a_line_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.line_end) |=> (state_ff == '0))
      else $error("parse state not cleared after line end");

   a_stopped_no_token: assert property (@(posedge clock) disable iff (reset)
      state_ff.line_stopped |-> !state_ff.token_open)
      else $error("token left open on a stopped line");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.kind == KIND_DONE)) |-> rsp_payload.last_of_run)
      else $error("line done response not last of its run");

   a_stopped_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && state_ff.line_stopped) |-> (step.count == 2'd0))
      else $error("stopped line produced a response");

endmodule

FILE: rtl/qet_csr.sv
module qet_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [6:0]  max_tokens
);
   import qet_pkg::*;

   logic [6:0] max_tokens_ff;
   logic [6:0] max_tokens_in;
   logic       write_en;

   assign pready   = 1'b1;
   assign write_en = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_TOKENS);

   always_comb begin
      max_tokens_in = max_tokens_ff;
      if (write_en) begin
         max_tokens_in = pwdata[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_tokens_ff <= MAX_TOKENS_RESET;
      end else begin
         max_tokens_ff <= max_tokens_in;
      end
   end

   // Only the low two address bits are ignored; word one reads as zero.
   assign prdata     = (paddr[2] == REG_MAX_TOKENS) ? {25'd0, max_tokens_ff} : 32'd0;
   assign max_tokens = max_tokens_ff;

endmodule

FILE: rtl/qet_step.sv
module qet_step (
   input  qet_pkg::state_type cur,
   input  qet_pkg::req_type   req,
   input  logic [6:0]         max_tokens,
   output qet_pkg::state_type nxt,
   output qet_pkg::step_type  step
);
   import qet_pkg::*;

   logic [8:0] limit;
   logic [7:0] quote_char;
   logic [7:0] c;
   logic       literal;
   logic       stop;
   logic       in_quote;
   logic [1:0] n;

   // The limit in force saturates at the build-time ceiling.
   assign limit = ({2'd0, max_tokens} < 9'(TOKEN_LIMIT)) ? {2'd0, max_tokens}
                                                         : 9'(TOKEN_LIMIT);
   assign c     = req.char_in;

   always_comb begin
      quote_char = CHAR_NUL;
      in_quote   = 1'b0;
      case (cur.quote_mode)
         QUOTE_SINGLE: begin
            quote_char = CHAR_SQUOTE;
            in_quote   = 1'b1;
         end
         QUOTE_DOUBLE: begin
            quote_char = CHAR_DQUOTE;
            in_quote   = 1'b1;
         end
         default: begin
            quote_char = CHAR_NUL;
            in_quote   = 1'b0;
         end
      endcase
   end

   always_comb begin
      nxt     = cur;
      step    = '0;
      n       = 2'd0;
      literal = 1'b0;
      stop    = 1'b0;
      if (!cur.line_stopped) begin
         if (c == CHAR_NUL) begin
            stop = 1'b1;
         end else begin
            if (cur.escape_pending) begin
               literal = 1'b1;
            end else if (c == CHAR_BACKSLASH) begin
               nxt.escape_pending = 1'b1;
            end else if (in_quote) begin
               if (c == quote_char) begin
                  nxt.quote_mode = QUOTE_NONE;
               end else begin
                  literal = 1'b1;
               end
            end else if (c == CHAR_SPACE) begin
               if (cur.token_open) begin
                  step.result[n].kind         = KIND_END;
                  step.result[n].token_number = cur.token_count[5:0];
                  n               = n + 2'd1;
                  nxt.token_open  = 1'b0;
                  nxt.token_count = cur.token_count + 7'd1;
               end
            end else if (c == CHAR_SQUOTE) begin
               nxt.quote_mode = QUOTE_SINGLE;
            end else if (c == CHAR_DQUOTE) begin
               nxt.quote_mode = QUOTE_DOUBLE;
            end else begin
               literal = 1'b1;
            end
            if (literal) begin
               if (!nxt.token_open) begin
                  if ({2'd0, nxt.token_count} >= limit) begin
                     stop = 1'b1;
                  end else begin
                     nxt.token_open = 1'b1;
                  end
               end
               if (!stop) begin
                  step.result[n].kind         = KIND_BYTE;
                  step.result[n].char_out     = c;
                  step.result[n].token_number = nxt.token_count[5:0];
                  n                  = n + 2'd1;
                  nxt.escape_pending = 1'b0;
               end
            end
         end
         if (stop || req.line_end) begin
            if (nxt.token_open) begin
               step.result[n].kind         = KIND_END;
               step.result[n].token_number = nxt.token_count[5:0];
               n               = n + 2'd1;
               nxt.token_open  = 1'b0;
               nxt.token_count = nxt.token_count + 7'd1;
            end
            step.result[n].kind        = KIND_DONE;
            step.result[n].token_total = nxt.token_count;
            n = n + 2'd1;
         end
         if (stop) begin
            nxt.line_stopped = 1'b1;
         end
      end
      if (req.line_end) begin
         nxt = '0;
      end
      if (n != 2'd0) begin
         step.result[n - 2'd1].last_of_run = 1'b1;
      end
      step.count = n;
   end

endmodule

FILE: rtl/qet_out.sv
module qet_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  qet_pkg::step_type step,
   output logic              free,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output qet_pkg::rsp_type  rsp_payload
);
   import qet_pkg::*;

   rsp_type [2:0] held_ff;
   rsp_type [2:0] held_in;
   logic    [1:0] count_ff;
   logic    [1:0] count_in;
   logic    [1:0] index_ff;
   logic    [1:0] index_in;
   logic          take;
   logic          last;

   assign rsp_valid   = (count_ff != 2'd0);
   assign rsp_payload = held_ff[index_ff];
   assign take        = rsp_valid && rsp_ready;
   assign last        = take && (index_ff == count_ff - 2'd1);
   assign free        = !rsp_valid || last;

   always_comb begin
      held_in  = held_ff;
      count_in = count_ff;
      index_in = index_ff;
      if (load && (step.count != 2'd0)) begin
         held_in  = step.result;
         count_in = step.count;
         index_in = 2'd0;
      end else if (last) begin
         count_in = 2'd0;
         index_in = 2'd0;
      end else if (take) begin
         index_in = index_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         index_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
         index_ff <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (index_ff < count_ff))
      else $error("result index beyond held count");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      (load && (step.count != 2'd0)) |-> free)
      else $error("results loaded over undelivered results");

endmodule
